FILE: hw/rtl/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

  // Configuration register indexes
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_RX_ID  = 1'b1;

  // Register reset values
  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam logic [7:0] RX_ID_RESET  = 8'hFC;

  // Shortest legal length byte: function byte plus checksum plus length itself
  localparam logic [7:0] MIN_LEN = 8'd3;

  // Frame parser phase
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_e;

  // Readout sequencer state
  typedef enum logic [1:0] {
    RD_IDLE,
    RD_READ,
    RD_LOAD
  } rd_state_e;

  // Parser to readout: a checked frame is ready in the store
  typedef struct packed {
    logic       start;
    logic [7:0] last_idx;  // store index of the final byte to emit
  } rdo_req_t;

endpackage

FILE: hw/rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sfr_parser.sv
// Frame parser: sync hunt, length check, body store and checksum.
module sfr_parser import sfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            byte_valid_i,
  input  logic [7:0]                      byte_i,
  input  logic [7:0]                      header_i,
  input  logic [7:0]                      rx_id_i,
  output logic                            we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] waddr_o,
  output rdo_req_t                        req_o
);

  localparam int         AW      = $clog2(BUFFER_DEPTH);
  localparam logic [7:0] MAX_LEN = 8'(BUFFER_DEPTH + 1);

  phase_e          phase_q, phase_d;
  logic [7:0]      len_q, len_d;
  logic [AW-1:0]   fill_q, fill_d;
  logic [7:0]      sum_q, sum_d;
  logic            body_end;

  // Final body byte is the checksum at index length - 2
  assign body_end = (8'(fill_q) == (len_q - 8'd2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
    end
  end

  // Next phase, store write and frame-good request
  always_comb begin
    phase_d      = phase_q;
    len_d        = len_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    we_o         = 1'b0;
    req_o.start  = 1'b0;
    req_o.last_idx = len_q - 8'd3;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == header_i) begin
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          // id match wins over a repeated header
          if (byte_i == rx_id_i) begin
            phase_d = PH_LEN;
          end else if (byte_i != header_i) begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          len_d = byte_i;
          if (byte_i >= MIN_LEN && byte_i <= MAX_LEN) begin
            fill_d  = '0;
            sum_d   = byte_i;
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          we_o = 1'b1;
          if (body_end) begin
            req_o.start = (sum_q == byte_i);
            fill_d      = '0;
            phase_d     = PH_HUNT;
          end else begin
            sum_d  = sum_q + byte_i;
            fill_d = fill_q + AW'(1);
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  assign waddr_o = fill_q;

endmodule

FILE: hw/rtl/sfr_reader.sv
// Readout sequencer: reads a checked frame from the store into the output register.
module sfr_reader import sfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rdo_req_t                        req_i,
  output logic                            re_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr_o,
  input  logic [7:0]                      rdata_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            out_func_o,
  output logic                            out_last_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  rd_state_e     state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] last_q, last_d;
  logic          valid_q, valid_d;
  logic [7:0]    byte_q, byte_d;
  logic          func_q, func_d;
  logic          tlast_q, tlast_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RD_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    func_q  <= func_d;
    tlast_q <= tlast_d;
  end

  // Read one entry once the output register is empty, load it in the next cycle
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    last_d  = last_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    func_d  = func_q;
    tlast_d = tlast_q;
    re_o    = 1'b0;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      RD_IDLE: begin
        if (req_i.start) begin
          idx_d   = '0;
          last_d  = req_i.last_idx[AW-1:0];
          state_d = RD_READ;
        end
      end
      RD_READ: begin
        if (!valid_q) begin
          re_o    = 1'b1;
          state_d = RD_LOAD;
        end
      end
      RD_LOAD: begin
        valid_d = 1'b1;
        byte_d  = rdata_i;
        func_d  = (idx_q == '0);
        tlast_d = (idx_q == last_q);
        if (idx_q == last_q) begin
          state_d = RD_IDLE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = RD_READ;
        end
      end
      default: state_d = RD_IDLE;
    endcase
  end

  assign raddr_o     = idx_q;
  assign busy_o      = (state_q != RD_IDLE);
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_func_o  = func_q;
  assign out_last_o  = tlast_q;

endmodule

FILE: hw/rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver.
//
// Receives one byte per transfer on the s_axis channel. The receiver hunts for
// the header byte and the id byte, takes a length byte L (3 to BUFFER_DEPTH+1),
// then L-1 body bytes: function byte, payload and an additive checksum. Body
// bytes go into a frame store RAM as they arrive. When the checksum matches,
// the function byte (tuser high) and the payload follow on m_axis, the final
// byte with tlast high; a bad frame produces no output.
// Input bytes are accepted back to back while s_axis_tready is high. After
// the checksum byte of a good frame the readout sequencer takes each output
// byte through RAM read, load and output transfer; s_axis_tready stays low
// until the final byte sits in the output register, where it may wait while new
// bytes are accepted. A stalled m_axis holds its byte and stalls the readout,
// and through it the input side. Configuration writes (header and id byte) take
// effect at once and must be made while the block is idle; nothing enforces it.
// Reset returns to the header hunt with an empty output register and the
// register defaults 0xFF and 0xFC; the frame store needs no clearing.
module serial_frame_receiver import sfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // Received bytes
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  // Checked frame bytes
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] frame_byte
  output logic       m_axis_tuser,   // [0] is_function
  output logic       m_axis_tlast
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0]    header_q;
  logic [7:0]    rx_id_q;
  logic          in_xfer;
  logic          busy;
  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  rdo_req_t      req;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      rx_id_q  <= RX_ID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEADER: header_q <= cfg_wdata_i;
        REG_RX_ID:  rx_id_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  sfr_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_xfer),
    .byte_i       (s_axis_tdata),
    .header_i     (header_q),
    .rx_id_i      (rx_id_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .req_o        (req)
  );

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sfr_reader #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_reader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_func_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/sfr_checker.sv
// Port-level checks of the serial frame receiver, bound to the top level.
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_idx_i,
  input logic [7:0] cfg_wdata_i,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // No output is offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // A stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Input is held off while a frame is still being read out
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready during frame readout");

  // The byte after a non-final output transfer is never a function byte
  a_func_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tuser || !m_axis_tvalid)
    else $error("function byte inside a frame");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
